FILE: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// sfr_pkg: shared types and constants for the serial frame receiver.
// No dependencies; used by the top level.
package sfr_pkg;

  // Parser states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_HEAD1  = 3'd1,
    ST_HEAD2  = 3'd2,
    ST_CMD    = 3'd3,
    ST_LENHI  = 3'd4,
    ST_DATA   = 3'd5,
    ST_TRAIL1 = 3'd6,
    ST_TRAIL2 = 3'd7
  } parse_state_t;

  // Result kinds
  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0,
    RK_DONE    = 2'd1,
    RK_LENERR  = 2'd2
  } result_kind_t;

  // Request kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Configuration register map (word index on paddr[3:2])
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;

  // Register reset values
  localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;
  localparam logic [15:0] MAX_LENGTH_RST    = 16'd256;

  // One result as held in the output stages
  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   command;
    logic [15:0]  out_length;
    logic [15:0]  byte_index;
    logic [7:0]   payload_byte;
    logic [31:0]  errors;
  } result_t;

endpackage

FILE: rtl/core/sfr_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the serial frame receiver.
// Depends on nothing but plain logic types; follows sfr_pkg in compile order.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  command;
  logic [15:0] out_length;
  logic [15:0] byte_index;
  logic [7:0]  payload_byte;
  logic [31:0] errors;

  modport source (output valid, output result_kind, output command, output out_length,
                  output byte_index, output payload_byte, output errors, input ready);
  modport sink   (input valid, input result_kind, input command, input out_length,
                  input byte_index, input payload_byte, input errors, output ready);
endinterface

FILE: rtl/core/serial_frame_receiver.sv
`timescale 1ns / 1ps
// Serial frame receiver: header/command/length frame parser, one byte per request.
// Results: each result is held in the output register, or in the skid register while out_ch stalls.
// Throughput: one request per cycle while the skid register is empty; the parser state and a
// two-deep output stage (output register plus skid register) set that figure.
// Reset: synchronous, active-low rst_n; registers return to their defaults, parser idles.
// Depends on sfr_pkg and the channel interfaces in sfr_intf.sv.
module serial_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  sfr_in_if.sink                          in_ch,
  sfr_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // Configuration registers
  logic [7:0]  hdr_first_r;
  logic [7:0]  hdr_second_r;
  logic [15:0] max_len_r;

  // Parser state
  sfr_pkg::parse_state_t state_r, state_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [31:0] err_r, err_nxt;

  // Output stages
  logic             out_valid_r;
  sfr_pkg::result_t out_data_r;
  logic             skid_valid_r;
  sfr_pkg::result_t skid_data_r;

  logic             accept;
  logic             pop;
  logic             res_valid;
  sfr_pkg::result_t res;
  logic [15:0]      len_full;
  logic [15:0]      pos_inc;
  logic             cfg_write;

  assign accept   = in_ch.valid && in_ch.ready;
  assign pop      = out_valid_r && out_ch.ready;
  assign len_full = {len_r[15:8], in_ch.rx_byte};
  assign pos_inc  = pos_r + 16'd1;

  // APB register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= sfr_pkg::HEADER_FIRST_RST;
      hdr_second_r <= sfr_pkg::HEADER_SECOND_RST;
      max_len_r    <= sfr_pkg::MAX_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        sfr_pkg::REG_HEADER_FIRST:  hdr_first_r  <= pwdata[7:0];
        sfr_pkg::REG_HEADER_SECOND: hdr_second_r <= pwdata[7:0];
        sfr_pkg::REG_MAX_LENGTH:    max_len_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sfr_pkg::REG_HEADER_FIRST:  prdata = {24'd0, hdr_first_r};
      sfr_pkg::REG_HEADER_SECOND: prdata = {24'd0, hdr_second_r};
      sfr_pkg::REG_MAX_LENGTH:    prdata = {16'd0, max_len_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // Next parser state
  always_comb begin
    state_nxt = state_r;
    if (in_ch.kind == sfr_pkg::KIND_CLEAR) begin
      state_nxt = sfr_pkg::ST_IDLE;
    end else begin
      unique case (state_r)
        sfr_pkg::ST_IDLE: begin
          if (in_ch.rx_byte == hdr_first_r) state_nxt = sfr_pkg::ST_HEAD1;
        end
        sfr_pkg::ST_HEAD1: begin
          // second header wins when both header bytes match
          priority if (in_ch.rx_byte == hdr_second_r) state_nxt = sfr_pkg::ST_HEAD2;
          else if (in_ch.rx_byte != hdr_first_r)     state_nxt = sfr_pkg::ST_IDLE;
          else                                       state_nxt = sfr_pkg::ST_HEAD1;
        end
        sfr_pkg::ST_HEAD2: state_nxt = sfr_pkg::ST_CMD;
        sfr_pkg::ST_CMD:   state_nxt = sfr_pkg::ST_LENHI;
        sfr_pkg::ST_LENHI: begin
          priority if (len_full > max_len_r) state_nxt = sfr_pkg::ST_IDLE;
          else if (len_full == 16'd0)         state_nxt = sfr_pkg::ST_TRAIL1;
          else                                state_nxt = sfr_pkg::ST_DATA;
        end
        sfr_pkg::ST_DATA: begin
          if (pos_inc >= len_r) state_nxt = sfr_pkg::ST_TRAIL1;
        end
        sfr_pkg::ST_TRAIL1: state_nxt = sfr_pkg::ST_TRAIL2;
        sfr_pkg::ST_TRAIL2: state_nxt = sfr_pkg::ST_IDLE;
        default:            state_nxt = sfr_pkg::ST_IDLE;
      endcase
    end
  end

  // Frame fields, error count and the result of this request
  always_comb begin
    cmd_nxt          = cmd_r;
    len_nxt          = len_r;
    pos_nxt          = pos_r;
    err_nxt          = err_r;
    res_valid        = 1'b0;
    res.result_kind  = sfr_pkg::RK_PAYLOAD;
    res.byte_index   = 16'd0;
    res.payload_byte = 8'd0;
    if (in_ch.kind == sfr_pkg::KIND_CLEAR) begin
      cmd_nxt = 8'd0;
      len_nxt = 16'd0;
      pos_nxt = 16'd0;
      err_nxt = 32'd0;
    end else begin
      unique case (state_r)
        sfr_pkg::ST_HEAD2: cmd_nxt = in_ch.rx_byte;
        sfr_pkg::ST_CMD:   len_nxt = {in_ch.rx_byte, 8'd0};
        sfr_pkg::ST_LENHI: begin
          len_nxt = len_full;
          if (len_full > max_len_r) begin
            err_nxt         = err_r + 32'd1;
            res_valid       = 1'b1;
            res.result_kind = sfr_pkg::RK_LENERR;
          end else begin
            pos_nxt = 16'd0;
          end
        end
        sfr_pkg::ST_DATA: begin
          pos_nxt          = pos_inc;
          res_valid        = 1'b1;
          res.result_kind  = sfr_pkg::RK_PAYLOAD;
          res.byte_index   = pos_r;
          res.payload_byte = in_ch.rx_byte;
        end
        sfr_pkg::ST_TRAIL2: begin
          res_valid       = 1'b1;
          res.result_kind = sfr_pkg::RK_DONE;
        end
        default: ;
      endcase
    end
    // results report the frame fields and count as left by this request
    res.command    = cmd_nxt;
    res.out_length = len_nxt;
    res.errors     = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfr_pkg::ST_IDLE;
      cmd_r   <= 8'd0;
      len_r   <= 16'd0;
      pos_r   <= 16'd0;
      err_r   <= 32'd0;
    end else if (accept) begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

  // Output register with skid stage; input stalls only when the skid is full
  assign in_ch.ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (accept && res_valid && out_valid_r && !pop) begin
      skid_data_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_data_r.result_kind;
  assign out_ch.command      = out_data_r.command;
  assign out_ch.out_length   = out_data_r.out_length;
  assign out_ch.byte_index   = out_data_r.byte_index;
  assign out_ch.payload_byte = out_data_r.payload_byte;
  assign out_ch.errors       = out_data_r.errors;

endmodule
